// ----- src/binary_morphology_window_unit_assert.svh -----
// Assertion macros shared by the morphology window design.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef BINARY_MORPHOLOGY_WINDOW_UNIT_ASSERT_SVH
`define BINARY_MORPHOLOGY_WINDOW_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define BMW_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("binary morphology window check failed");

// The consequence must hold in the cycle after the condition.
`define BMW_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("binary morphology window check failed");

`endif

// ----- src/bmw_pkg.sv -----
`default_nettype none

package bmw_pkg;

   // Image and kernel limits.
   localparam int MAX_WIDTH  = 1024;
   localparam int ROW_LIMIT  = 1024;
   localparam int MAX_KERNEL = 7;

   // Field widths.
   localparam int PIXEL_W    = 8;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(ROW_LIMIT);
   localparam int SIZE_W     = 11;
   localparam int KSIZE_W    = 3;
   localparam int WIN_W      = MAX_KERNEL * MAX_KERNEL;
   localparam int LINE_W     = MAX_KERNEL - 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 49;

   // Result values.
   localparam logic [PIXEL_W-1:0] VALUE_SET   = 8'd255;
   localparam logic [PIXEL_W-1:0] VALUE_CLEAR = 8'd0;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_THRESHOLD    = 3'd2,
      CSR_OP_MODE      = 3'd3,
      CSR_KERNEL_ROWS  = 3'd4,
      CSR_KERNEL_COLS  = 3'd5,
      CSR_KERNEL_MASK  = 3'd6
   } csr_index_type;

   // Effective configuration seen by the datapath.
   typedef struct packed {
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic [PIXEL_W-1:0] threshold;
      logic               op_mode;
      logic [KSIZE_W-1:0] span_rows;
      logic [KSIZE_W-1:0] span_cols;
      logic [WIN_W-1:0]   window_mask;
   } cfg_type;

   // Raster position of one request.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } pos_type;

   // One request in the working stage.
   typedef struct packed {
      pos_type pos;
      logic    pix_bit;
   } item_type;

   // One result.
   typedef struct packed {
      logic [PIXEL_W-1:0] value;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic               frame_end;
   } result_type;

   // Zero kernel size becomes one, even sizes drop to the next odd size.
   function automatic logic [KSIZE_W-1:0] eff_kernel(input logic [KSIZE_W-1:0] k);
      logic [KSIZE_W-1:0] res;
      if (k == '0) begin
         res = KSIZE_W'(1);
      end else if (k[0] == 1'b0) begin
         res = k - KSIZE_W'(1);
      end else begin
         res = k;
      end
      return res;
   endfunction

   // Zero image size becomes one, larger sizes clamp to the limit.
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] lim);
      logic [SIZE_W-1:0] res;
      if (v == '0) begin
         res = SIZE_W'(1);
      end else if (v > lim) begin
         res = lim;
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- src/bmw_ram.sv -----
`default_nettype none

module bmw_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; a read at the written
   // address returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/bmw_csr.sv -----
`default_nettype none

module bmw_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bmw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bmw_pkg::CSR_DATA_W-1:0]   csr_data,
   output bmw_pkg::cfg_type                      cfg
);

   logic [bmw_pkg::SIZE_W-1:0]  width_ff, width_in;
   logic [bmw_pkg::SIZE_W-1:0]  height_ff, height_in;
   logic [bmw_pkg::PIXEL_W-1:0] threshold_ff, threshold_in;
   logic                        op_mode_ff, op_mode_in;
   logic [bmw_pkg::KSIZE_W-1:0] krows_ff, krows_in;
   logic [bmw_pkg::KSIZE_W-1:0] kcols_ff, kcols_in;
   logic [bmw_pkg::WIN_W-1:0]   kmask_ff, kmask_in;
   logic [bmw_pkg::WIN_W-1:0]   window_mask_ff, window_mask_in;
   logic                        csr_write;

   // Place the element mask in the bottom right corner of the window and drop
   // bits outside the effective element.
   function automatic logic [bmw_pkg::WIN_W-1:0] align_mask(
      input logic [bmw_pkg::WIN_W-1:0]   mask,
      input logic [bmw_pkg::KSIZE_W-1:0] kr,
      input logic [bmw_pkg::KSIZE_W-1:0] kc
   );
      logic [bmw_pkg::KSIZE_W-1:0] orow;
      logic [bmw_pkg::KSIZE_W-1:0] ocol;
      logic [5:0]                  shift;
      logic [bmw_pkg::WIN_W-1:0]   shifted;
      logic [bmw_pkg::WIN_W-1:0]   region;
      orow    = bmw_pkg::KSIZE_W'(bmw_pkg::MAX_KERNEL) - kr;
      ocol    = bmw_pkg::KSIZE_W'(bmw_pkg::MAX_KERNEL) - kc;
      shift   = 6'(orow) * 6'(bmw_pkg::MAX_KERNEL) + 6'(ocol);
      shifted = mask << shift;
      for (int wr = 0; wr < bmw_pkg::MAX_KERNEL; wr++) begin
         for (int wc = 0; wc < bmw_pkg::MAX_KERNEL; wc++) begin
            region[wr * bmw_pkg::MAX_KERNEL + wc] =
               (bmw_pkg::KSIZE_W'(wr) >= orow) && (bmw_pkg::KSIZE_W'(wc) >= ocol);
         end
      end
      return shifted & region;
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register write decode; sizes are stored in their effective form.
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      threshold_in = threshold_ff;
      op_mode_in   = op_mode_ff;
      krows_in     = krows_ff;
      kcols_in     = kcols_ff;
      kmask_in     = kmask_ff;
      if (csr_write) begin
         unique case (bmw_pkg::csr_index_type'(csr_index))
            bmw_pkg::CSR_IMAGE_WIDTH: begin
               width_in = bmw_pkg::eff_size(csr_data[bmw_pkg::SIZE_W-1:0],
                                            bmw_pkg::SIZE_W'(bmw_pkg::MAX_WIDTH));
            end
            bmw_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = bmw_pkg::eff_size(csr_data[bmw_pkg::SIZE_W-1:0],
                                             bmw_pkg::SIZE_W'(bmw_pkg::ROW_LIMIT));
            end
            bmw_pkg::CSR_THRESHOLD: begin
               threshold_in = csr_data[bmw_pkg::PIXEL_W-1:0];
            end
            bmw_pkg::CSR_OP_MODE: begin
               op_mode_in = csr_data[0];
            end
            bmw_pkg::CSR_KERNEL_ROWS: begin
               krows_in = bmw_pkg::eff_kernel(csr_data[bmw_pkg::KSIZE_W-1:0]);
            end
            bmw_pkg::CSR_KERNEL_COLS: begin
               kcols_in = bmw_pkg::eff_kernel(csr_data[bmw_pkg::KSIZE_W-1:0]);
            end
            bmw_pkg::CSR_KERNEL_MASK: begin
               kmask_in = csr_data[bmw_pkg::WIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The aligned mask is registered from the stored element, following it in the next cycle.
   assign window_mask_in = align_mask(kmask_ff, krows_ff, kcols_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= bmw_pkg::SIZE_W'(bmw_pkg::MAX_WIDTH);
         height_ff      <= bmw_pkg::SIZE_W'(bmw_pkg::ROW_LIMIT);
         threshold_ff   <= bmw_pkg::PIXEL_W'(127);
         op_mode_ff     <= 1'b0;
         krows_ff       <= bmw_pkg::KSIZE_W'(3);
         kcols_ff       <= bmw_pkg::KSIZE_W'(3);
         kmask_ff       <= bmw_pkg::WIN_W'(511);
         window_mask_ff <= align_mask(bmw_pkg::WIN_W'(511), bmw_pkg::KSIZE_W'(3),
                                      bmw_pkg::KSIZE_W'(3));
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         threshold_ff   <= threshold_in;
         op_mode_ff     <= op_mode_in;
         krows_ff       <= krows_in;
         kcols_ff       <= kcols_in;
         kmask_ff       <= kmask_in;
         window_mask_ff <= window_mask_in;
      end
   end

   assign cfg.width       = width_ff;
   assign cfg.height      = height_ff;
   assign cfg.threshold   = threshold_ff;
   assign cfg.op_mode     = op_mode_ff;
   assign cfg.span_rows   = krows_ff - bmw_pkg::KSIZE_W'(1);
   assign cfg.span_cols   = kcols_ff - bmw_pkg::KSIZE_W'(1);
   assign cfg.window_mask = window_mask_ff;

endmodule

`default_nettype wire

// ----- src/bmw_scan.sv -----
`default_nettype none

module bmw_scan (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire bmw_pkg::cfg_type cfg,
   output bmw_pkg::pos_type      pos
);

   logic [bmw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [bmw_pkg::ROW_W-1:0]  row_ff, row_in;
   logic                       col_wrap;
   logic [bmw_pkg::SIZE_W-1:0] row_step;
   logic [bmw_pkg::COL_W-1:0]  col_cur;
   logic [bmw_pkg::ROW_W-1:0]  row_cur;
   logic [bmw_pkg::SIZE_W-1:0] col_next;
   logic [bmw_pkg::SIZE_W-1:0] row_next;

   // Wrap counters that lie beyond a shrunken image before using them.
   always_comb begin
      col_wrap = {1'b0, col_ff} >= cfg.width;
      row_step = col_wrap ? ({1'b0, row_ff} + bmw_pkg::SIZE_W'(1)) : {1'b0, row_ff};
      col_cur  = col_wrap ? '0 : col_ff;
      row_cur  = (row_step >= cfg.height) ? '0 : row_step[bmw_pkg::ROW_W-1:0];
   end

   // Advance to the next raster position.
   always_comb begin
      col_next = {1'b0, col_cur} + bmw_pkg::SIZE_W'(1);
      row_next = {1'b0, row_cur} + bmw_pkg::SIZE_W'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_next >= cfg.width) begin
            col_in = '0;
            row_in = (row_next >= cfg.height) ? '0 : row_next[bmw_pkg::ROW_W-1:0];
         end else begin
            col_in = col_next[bmw_pkg::COL_W-1:0];
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign pos.row  = row_cur;
   assign pos.col  = col_cur;
   assign pos.last = ({1'b0, row_cur} == cfg.height - bmw_pkg::SIZE_W'(1)) &&
                     ({1'b0, col_cur} == cfg.width - bmw_pkg::SIZE_W'(1));

endmodule

`default_nettype wire

// ----- src/bmw_window.sv -----
`default_nettype none

module bmw_window (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            commit,
   input  wire bmw_pkg::item_type               item,
   input  wire logic [bmw_pkg::LINE_W-1:0]      line_rd,
   input  wire bmw_pkg::cfg_type                cfg,
   output logic                                 emit,
   output bmw_pkg::result_type                  result,
   output logic [bmw_pkg::LINE_W-1:0]           line_wr
);

   logic [bmw_pkg::WIN_W-1:0] window_ff, window_in;
   logic                      hit_any;
   logic                      hit_all;
   logic                      hit;

   // Shift every window row one column left; the new column enters on the
   // right, oldest line bit at the top and the current pixel at the bottom.
   always_comb begin
      for (int k = 0; k < bmw_pkg::MAX_KERNEL; k++) begin
         if (k == bmw_pkg::MAX_KERNEL - 1) begin
            window_in[k * bmw_pkg::MAX_KERNEL +: bmw_pkg::MAX_KERNEL] =
               {item.pix_bit,
                window_ff[k * bmw_pkg::MAX_KERNEL + 1 +: bmw_pkg::MAX_KERNEL - 1]};
         end else begin
            window_in[k * bmw_pkg::MAX_KERNEL +: bmw_pkg::MAX_KERNEL] =
               {line_rd[bmw_pkg::MAX_KERNEL - 2 - k],
                window_ff[k * bmw_pkg::MAX_KERNEL + 1 +: bmw_pkg::MAX_KERNEL - 1]};
         end
      end
   end

   // The column history for this position gains the current bit.
   assign line_wr = {line_rd[bmw_pkg::LINE_W-2:0], item.pix_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (commit) begin
         window_ff <= window_in;
      end
   end

   // Apply the structuring element to the updated window.
   always_comb begin
      hit_any = |(window_in & cfg.window_mask);
      hit_all = &(window_in | ~cfg.window_mask);
      hit     = cfg.op_mode ? hit_all : hit_any;
   end

   // A result exists only when the whole element fits inside the image.
   assign emit = (item.pos.row >= bmw_pkg::ROW_W'(cfg.span_rows)) &&
                 (item.pos.col >= bmw_pkg::COL_W'(cfg.span_cols));

   assign result.value     = hit ? bmw_pkg::VALUE_SET : bmw_pkg::VALUE_CLEAR;
   assign result.row       = item.pos.row - bmw_pkg::ROW_W'(cfg.span_rows >> 1);
   assign result.col       = item.pos.col - bmw_pkg::COL_W'(cfg.span_cols >> 1);
   assign result.frame_end = item.pos.last;

endmodule

`default_nettype wire

// ----- src/binary_morphology_window_unit.sv -----
// Binary dilation and erosion over a streamed raster image.
// Request channel (req_valid, req_stall, req_pixel): one 8-bit pixel per
// request in raster order; the pixel is set when it exceeds the threshold.
// Response channel (rsp_valid, rsp_stall, rsp_*): one result for each window
// centre whose element fits inside the image, with its row and column, and
// rsp_frame_end on the result made by the last pixel of the frame.
// Configuration channel (csr_valid, csr_ready, csr_index, csr_data): always
// ready; write only while no request is in flight.
// Throughput is one pixel per cycle unless the input stage is held: a pixel
// enters an input stage while the line store is read; from that stage the window
// is shifted and the element applied, straight into the response register.
// An accepted request passes the input stage and then the response register.
// When the receiver stalls, the held result keeps its value; one more pixel
// can wait in the input stage, after which req_stall rises. Pixels that make
// no result keep flowing while the response register is full.
// Reset restores the default registers, clears the window and the raster
// position; the line store needs no clearing.
`default_nettype none

`include "binary_morphology_window_unit_assert.svh"

module binary_morphology_window_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [bmw_pkg::PIXEL_W-1:0]    req_pixel,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [bmw_pkg::PIXEL_W-1:0]         rsp_out_value,
   output logic [bmw_pkg::ROW_W-1:0]           rsp_out_row,
   output logic [bmw_pkg::COL_W-1:0]           rsp_out_col,
   output logic                                rsp_frame_end,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bmw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bmw_pkg::CSR_DATA_W-1:0] csr_data
);

   bmw_pkg::cfg_type            cfg;
   bmw_pkg::pos_type            pos;
   bmw_pkg::item_type           s1_item_ff;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        fwd_hit_ff, fwd_hit_in;
   logic [bmw_pkg::LINE_W-1:0]  fwd_data_ff;
   logic [bmw_pkg::LINE_W-1:0]  ram_rd_data;
   logic [bmw_pkg::LINE_W-1:0]  line_rd;
   logic [bmw_pkg::LINE_W-1:0]  line_wr;
   logic                        emit;
   bmw_pkg::result_type         result;
   bmw_pkg::result_type         rsp_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        accept;
   logic                        commit;
   logic                        out_free;

   bmw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bmw_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cfg    (cfg),
      .pos    (pos)
   );

   // Per-column history of the last rows' thresholded bits.
   bmw_ram #(
      .WIDTH (bmw_pkg::LINE_W),
      .DEPTH (bmw_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (s1_item_ff.pos.col),
      .wr_data (line_wr),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (ram_rd_data)
   );

   bmw_window u_window (
      .clock   (clock),
      .reset   (reset),
      .commit  (commit),
      .item    (s1_item_ff),
      .line_rd (line_rd),
      .cfg     (cfg),
      .emit    (emit),
      .result  (result),
      .line_wr (line_wr)
   );

   // Handshake: the working stage moves on unless its result has nowhere to go.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = s1_valid_ff && (!emit || out_free);
   assign req_stall = s1_valid_ff && !commit;
   assign accept    = req_valid && !req_stall;

   // A one-pixel-wide image reads the column that is being written in the
   // same cycle, so that write is carried forward past the memory.
   assign line_rd = fwd_hit_ff ? fwd_data_ff : ram_rd_data;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (commit) begin
         s1_valid_in = 1'b0;
      end
      fwd_hit_in = fwd_hit_ff;
      if (accept) begin
         fwd_hit_in = commit && (s1_item_ff.pos.col == pos.col);
      end
   end

   // Response register control.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.pos     <= pos;
         s1_item_ff.pix_bit <= req_pixel > cfg.threshold;
         fwd_data_ff        <= line_wr;
      end
      if (commit && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_ff.value;
   assign rsp_out_row   = rsp_ff.row;
   assign rsp_out_col   = rsp_ff.col;
   assign rsp_frame_end = rsp_ff.frame_end;

   // An accepted request always occupies the working stage next cycle.
   `BMW_ASSERT_NEXT(a_accept_fills_stage, clock, reset, accept, s1_valid_ff)
   // A request held in the working stage keeps its position.
   `BMW_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !commit, s1_valid_ff && $stable(s1_item_ff.pos.col))
   // Forwarding past the line store only happens for one-pixel-wide images.
   `BMW_ASSERT_IMPLY(a_bypass_narrow, clock, reset, fwd_hit_ff && s1_valid_ff, cfg.width == bmw_pkg::SIZE_W'(1))

endmodule

`default_nettype wire
